// File: hdl/nnis_pkg.sv
// shared constants, codes and controller/datapath interface types for the image scaler
package nnis_pkg;

  localparam int MAX_SRC_WIDTH  = 256;
  localparam int MAX_SRC_HEIGHT = 256;
  localparam int PIXEL_BITS     = 64;

  localparam int STORE_DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int CNT_W       = 17;
  localparam int DIM_W       = 9;
  localparam int SCALE_W     = 13;
  localparam int COORD_W     = 12;
  localparam int ODIM_W      = 13;
  localparam int QUOT_W      = COORD_W + 8;
  localparam int DIV_STEPS   = QUOT_W;
  localparam int STEP_W      = $clog2(DIV_STEPS);
  localparam int OUT_DIM_LIMIT = 4096;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE       = 2'd2;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_FETCH = 1'b1;

  typedef struct packed {
    logic load;
    logic set_done;
    logic null_res;
    logic div_start;
    logic div_step;
    logic mul_en;
    logic addr_en;
    logic rd_en;
    logic res_en;
  } nnis_cmd_t;

  typedef struct packed {
    logic loaded;
    logic emit_done;
    logic pos_ok;
    logic out_free;
  } nnis_sts_t;

endpackage

// File: hdl/nnis_div.sv
// restoring divider lane, one quotient bit per step
module nnis_div (
  input  logic                        clk,
  input  logic                        start,
  input  logic                        step,
  input  logic [nnis_pkg::QUOT_W-1:0]  numer,
  input  logic [nnis_pkg::SCALE_W-1:0] denom,
  output logic [nnis_pkg::QUOT_W-1:0]  quot
);

  logic [nnis_pkg::SCALE_W-1:0] rem_r, rem_nxt;
  logic [nnis_pkg::QUOT_W-1:0]  quo_r, quo_nxt;
  logic [nnis_pkg::SCALE_W:0]   trial;
  logic [nnis_pkg::SCALE_W:0]   diff;
  logic                         qbit;

  always_comb begin
    trial   = {rem_r, quo_r[nnis_pkg::QUOT_W-1]};
    diff    = trial - {1'b0, denom};
    qbit    = (trial >= {1'b0, denom});
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    if (start) begin
      rem_nxt = '0;
      quo_nxt = numer;
    end else if (step) begin
      rem_nxt = qbit ? diff[nnis_pkg::SCALE_W-1:0] : trial[nnis_pkg::SCALE_W-1:0];
      quo_nxt = {quo_r[nnis_pkg::QUOT_W-2:0], qbit};
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign quot = quo_r;

endmodule

// File: hdl/nnis_dpath.sv
// scaler datapath: registers, counters, frame store, coordinate dividers and result register
module nnis_dpath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [nnis_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [nnis_pkg::SCALE_W-1:0]   cfg_wr_data,
  input  logic [63:0]                    in_pixel_in,
  input  logic                           out_stall,
  input  nnis_pkg::nnis_cmd_t            cmd,
  output nnis_pkg::nnis_sts_t            sts,
  output logic                           out_valid,
  output logic                           out_valid_res,
  output logic [63:0]                    out_pixel_out,
  output logic [11:0]                    out_out_x,
  output logic [11:0]                    out_out_y,
  output logic                           out_frame_last
);

  localparam int DIM_W   = nnis_pkg::DIM_W;
  localparam int PROD_W  = nnis_pkg::QUOT_W + DIM_W;
  localparam int SUM_W   = PROD_W + 1;
  localparam int OW_W    = DIM_W + nnis_pkg::SCALE_W;
  localparam int ODIM_W_L = nnis_pkg::ODIM_W;

  logic [DIM_W-1:0]             src_width_r, src_height_r;
  logic [nnis_pkg::SCALE_W-1:0] scale_r;

  logic [nnis_pkg::CNT_W-1:0]   load_count_r;
  logic [nnis_pkg::COORD_W-1:0] emit_col_r, emit_row_r;
  logic                         emit_done_r;

  logic [nnis_pkg::PIXEL_BITS-1:0] frame_store [0:nnis_pkg::STORE_DEPTH-1];
  logic [nnis_pkg::PIXEL_BITS-1:0] rd_data_r;
  logic [nnis_pkg::ADDR_W-1:0]     wr_addr;

  logic [DIM_W-1:0]             sw, sh;
  logic [nnis_pkg::CNT_W-1:0]   total;
  logic [OW_W-1:0]              ow_full, oh_full;
  logic [ODIM_W_L-1:0]          ow, oh;
  logic                         loaded;

  logic [nnis_pkg::QUOT_W-1:0]  qx, qy;
  logic [PROD_W-1:0]            prod_r;
  logic [SUM_W-1:0]             sum;
  logic [nnis_pkg::ADDR_W-1:0]  addr_r;

  logic                         out_valid_r, valid_res_r, last_r;
  logic [63:0]                  pixel_r;
  logic [11:0]                  x_r, y_r;
  logic                         out_free;
  logic                         row_wrap, col_wrap;

  // effective sizes, zero read as one and oversize clamped
  always_comb begin
    if (src_width_r == '0) sw = DIM_W'(1);
    else if (src_width_r > DIM_W'(nnis_pkg::MAX_SRC_WIDTH)) sw = DIM_W'(nnis_pkg::MAX_SRC_WIDTH);
    else sw = src_width_r;
    if (src_height_r == '0) sh = DIM_W'(1);
    else if (src_height_r > DIM_W'(nnis_pkg::MAX_SRC_HEIGHT)) sh = DIM_W'(nnis_pkg::MAX_SRC_HEIGHT);
    else sh = src_height_r;
  end

  assign total   = nnis_pkg::CNT_W'(sw) * nnis_pkg::CNT_W'(sh);
  assign ow_full = (OW_W'(sw) * OW_W'(scale_r)) >> 8;
  assign oh_full = (OW_W'(sh) * OW_W'(scale_r)) >> 8;
  assign ow = (ow_full > OW_W'(nnis_pkg::OUT_DIM_LIMIT)) ?
              ODIM_W_L'(nnis_pkg::OUT_DIM_LIMIT) : ow_full[ODIM_W_L-1:0];
  assign oh = (oh_full > OW_W'(nnis_pkg::OUT_DIM_LIMIT)) ?
              ODIM_W_L'(nnis_pkg::OUT_DIM_LIMIT) : oh_full[ODIM_W_L-1:0];
  assign loaded = (load_count_r >= total);

  assign out_free = !out_valid_r || !out_stall;

  assign sts.loaded    = loaded;
  assign sts.emit_done = emit_done_r;
  assign sts.pos_ok    = (ow != '0) && (oh != '0) &&
                         ({1'b0, emit_col_r} < ow) && ({1'b0, emit_row_r} < oh);
  assign sts.out_free  = out_free;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= DIM_W'(256);
      src_height_r <= DIM_W'(256);
      scale_r      <= nnis_pkg::SCALE_W'(256);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        nnis_pkg::CFG_SRC_WIDTH:  src_width_r  <= cfg_wr_data[DIM_W-1:0];
        nnis_pkg::CFG_SRC_HEIGHT: src_height_r <= cfg_wr_data[DIM_W-1:0];
        nnis_pkg::CFG_SCALE:      scale_r      <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  assign row_wrap = !(({1'b0, emit_row_r} + ODIM_W_L'(1)) < oh);
  assign col_wrap = !(({1'b0, emit_col_r} + ODIM_W_L'(1)) < ow);

  // load counter and emit position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_count_r <= '0;
      emit_col_r   <= '0;
      emit_row_r   <= '0;
      emit_done_r  <= 1'b0;
    end else if (cmd.load) begin
      if (loaded) begin
        // a load after a complete frame starts a new one
        load_count_r <= nnis_pkg::CNT_W'(1);
        emit_col_r   <= '0;
        emit_row_r   <= '0;
        emit_done_r  <= 1'b0;
      end else begin
        load_count_r <= load_count_r + nnis_pkg::CNT_W'(1);
      end
    end else if (cmd.set_done) begin
      emit_done_r <= 1'b1;
    end else if (cmd.res_en) begin
      if (!row_wrap) begin
        emit_row_r <= emit_row_r + nnis_pkg::COORD_W'(1);
      end else begin
        emit_row_r <= '0;
        if (!col_wrap) begin
          emit_col_r <= emit_col_r + nnis_pkg::COORD_W'(1);
        end else begin
          emit_col_r  <= '0;
          emit_done_r <= 1'b1;
        end
      end
    end
  end

  // frame store
  assign wr_addr = loaded ? '0 : load_count_r[nnis_pkg::ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      frame_store[wr_addr] <= in_pixel_in[nnis_pkg::PIXEL_BITS-1:0];
    end
    if (cmd.rd_en) begin
      rd_data_r <= frame_store[addr_r];
    end
  end

  // source coordinates: floor(c*256/f) for column and row
  nnis_div u_div_x (
    .clk   (clk),
    .start (cmd.div_start),
    .step  (cmd.div_step),
    .numer ({emit_col_r, 8'h00}),
    .denom (scale_r),
    .quot  (qx)
  );

  nnis_div u_div_y (
    .clk   (clk),
    .start (cmd.div_start),
    .step  (cmd.div_step),
    .numer ({emit_row_r, 8'h00}),
    .denom (scale_r),
    .quot  (qy)
  );

  assign sum = SUM_W'(prod_r) + SUM_W'(qx);

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_r <= PROD_W'(qy) * PROD_W'(sw);
    end
    if (cmd.addr_en) begin
      // clamp to the last pixel of the frame
      addr_r <= (sum >= SUM_W'(total)) ? nnis_pkg::ADDR_W'(total - nnis_pkg::CNT_W'(1)) :
                sum[nnis_pkg::ADDR_W-1:0];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.res_en || cmd.null_res) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_en) begin
      valid_res_r <= 1'b1;
      pixel_r     <= 64'(rd_data_r);
      x_r         <= emit_col_r;
      y_r         <= emit_row_r;
      last_r      <= row_wrap && col_wrap;
    end else if (cmd.null_res) begin
      valid_res_r <= 1'b0;
      pixel_r     <= '0;
      x_r         <= '0;
      y_r         <= '0;
      last_r      <= 1'b0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_valid_res  = valid_res_r;
  assign out_pixel_out  = pixel_r;
  assign out_out_x      = x_r;
  assign out_out_y      = y_r;
  assign out_frame_last = last_r;

endmodule

// File: hdl/nnis_ctrl.sv
// scaler controller: sequences loads, fetches, the divider steps and the result transfer
module nnis_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_req_type,
  output logic                in_stall,
  input  nnis_pkg::nnis_sts_t sts,
  output nnis_pkg::nnis_cmd_t cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_ADDR = 3'd3;
  localparam logic [2:0] ST_READ = 3'd4;
  localparam logic [2:0] ST_RES  = 3'd5;
  localparam logic [2:0] ST_NULL = 3'd6;

  logic [2:0]                  state_r, state_nxt;
  logic [nnis_pkg::STEP_W-1:0] step_r, step_nxt;
  logic                        accept;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_req_type == nnis_pkg::REQ_LOAD) begin
            cmd.load = 1'b1;
          end else if (!sts.loaded || sts.emit_done) begin
            state_nxt = ST_NULL;
          end else if (!sts.pos_ok) begin
            // position off the output: frame counts as finished
            cmd.set_done = 1'b1;
            state_nxt    = ST_NULL;
          end else begin
            cmd.div_start = 1'b1;
            step_nxt      = '0;
            state_nxt     = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + nnis_pkg::STEP_W'(1);
        if (step_r == nnis_pkg::STEP_W'(nnis_pkg::DIV_STEPS - 1)) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = ST_ADDR;
      end
      ST_ADDR: begin
        cmd.addr_en = 1'b1;
        state_nxt   = ST_READ;
      end
      ST_READ: begin
        cmd.rd_en = 1'b1;
        state_nxt = ST_RES;
      end
      ST_RES: begin
        if (sts.out_free) begin
          cmd.res_en = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      ST_NULL: begin
        if (sts.out_free) begin
          cmd.null_res = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule

// File: hdl/nearest_neighbor_image_scaler_unit.sv
// Nearest-neighbour image scaler. Load transfers (req_type 0) write source pixels in
// row-major order into a 64K x 64-bit frame store and leave the block idle; a load after a
// complete frame starts a new one. Fetch transfers (req_type 1) return the scaled frame
// column by column, one output pixel per fetch, copying source pixel
// (floor(x*256/f), floor(y*256/f)) with f the Q5.8 scale factor. A fetch that yields a
// pixel passes in order through the bit-serial coordinate dividers, the row multiply,
// the address add and clamp, the frame store read and the result write. A fetch before
// the frame is loaded, at a position off the output or after its last pixel returns
// valid_res 0. The result register lets the next item be accepted while a result waits
// to be taken. Write the size and factor registers only while the block is idle.
module nearest_neighbor_image_scaler_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [nnis_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [nnis_pkg::SCALE_W-1:0]   cfg_wr_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_req_type,
  input  logic [63:0]                    in_pixel_in,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_valid_res,
  output logic [63:0]                    out_pixel_out,
  output logic [11:0]                    out_out_x,
  output logic [11:0]                    out_out_y,
  output logic                           out_frame_last
);

  nnis_pkg::nnis_cmd_t cmd;
  nnis_pkg::nnis_sts_t sts;

  nnis_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_req_type),
    .in_stall    (in_stall),
    .sts         (sts),
    .cmd         (cmd)
  );

  nnis_dpath u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wr_data    (cfg_wr_data),
    .in_pixel_in    (in_pixel_in),
    .out_stall      (out_stall),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_valid_res  (out_valid_res),
    .out_pixel_out  (out_pixel_out),
    .out_out_x      (out_out_x),
    .out_out_y      (out_out_y),
    .out_frame_last (out_frame_last)
  );

endmodule
